// ===== hw/rtl/ngh_pkg.sv =====
package ngh_pkg;

	// envelope format, unsigned Q1.16
	localparam int ENV_W = 17;
	localparam logic [ENV_W-1:0] ENV_ONE      = 17'd65536;
	localparam logic [ENV_W-1:0] ENV_OPEN_AT  = 17'd65470;
	localparam logic [ENV_W-1:0] ENV_CLOSE_AT = 17'd6;

	localparam int LEVEL_W     = 32;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;

	// register map
	localparam logic [CFG_INDEX_W-1:0] REG_OPEN_LEVEL    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_LEVEL   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_COEFF  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_COEFF = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD_SAMPLES  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_MUTE_MODE     = 3'd5;

	typedef enum logic [2:0] {
		PH_CLOSED  = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_OPEN    = 3'd2,
		PH_HOLD    = 3'd3,
		PH_RELEASE = 3'd4
	} phase_t;

	typedef enum logic {
		BK_STEP  = 1'b0,
		BK_SCALE = 1'b1
	} bk_state_t;

	// level compare results for one word
	typedef struct packed {
		logic above_open;
		logic below_close;
	} cmp_flags_t;

endpackage

// ===== hw/rtl/ngh_in_if.sv =====
interface ngh_in_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] in_x;
	logic signed [SAMPLE_WIDTH-1:0] in_y;
	logic signed [SAMPLE_WIDTH-1:0] in_z;

	modport source(output valid, output in_x, output in_y, output in_z, input ready);
	modport sink(input valid, input in_x, input in_y, input in_z, output ready);
endinterface

// ===== hw/rtl/ngh_out_if.sv =====
interface ngh_out_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] out_x;
	logic signed [SAMPLE_WIDTH-1:0] out_y;
	logic signed [SAMPLE_WIDTH-1:0] out_z;
	logic [2:0] gate_phase;
	logic [16:0] envelope_level;

	modport source(output valid, output out_x, output out_y, output out_z,
		output gate_phase, output envelope_level, input ready);
	modport sink(input valid, input out_x, input out_y, input out_z,
		input gate_phase, input envelope_level, output ready);
endinterface

// ===== hw/rtl/ngh_front.sv =====
module ngh_front #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	ngh_in_if.sink samples,
	input  logic [ngh_pkg::LEVEL_W-1:0] open_level_sq,
	input  logic [ngh_pkg::LEVEL_W-1:0] close_level_sq,
	output logic push_valid,
	input  logic push_ready,
	output logic signed [SAMPLE_WIDTH-1:0] push_x,
	output logic signed [SAMPLE_WIDTH-1:0] push_y,
	output logic signed [SAMPLE_WIDTH-1:0] push_z,
	output ngh_pkg::cmp_flags_t push_flags
);
	import ngh_pkg::*;

	localparam int SQ_W  = 2 * SAMPLE_WIDTH;
	localparam int MAG_W = SQ_W + 1;
	localparam int CMP_W = (MAG_W > LEVEL_W) ? MAG_W : LEVEL_W;

	logic v_s1;
	logic signed [SAMPLE_WIDTH-1:0] x_s1, y_s1, z_s1;
	logic [SQ_W-1:0] sqx_s1, sqy_s1;
	logic signed [SQ_W-1:0] sqx, sqy;
	logic [MAG_W-1:0] mag;
	logic [CMP_W-1:0] mag_c, open_c, close_c;
	logic take;

	assign samples.ready = !v_s1 || push_ready;
	assign take = samples.valid && samples.ready;

	assign sqx = samples.in_x * samples.in_x;
	assign sqy = samples.in_y * samples.in_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_s1   <= samples.in_x;
			y_s1   <= samples.in_y;
			z_s1   <= samples.in_z;
			sqx_s1 <= sqx;
			sqy_s1 <= sqy;
		end
	end

	// magnitude kept at full width, compared unsigned
	assign mag     = {1'b0, sqx_s1} + {1'b0, sqy_s1};
	assign mag_c   = CMP_W'(mag);
	assign open_c  = CMP_W'(open_level_sq);
	assign close_c = CMP_W'(close_level_sq);

	assign push_valid             = v_s1;
	assign push_x                 = x_s1;
	assign push_y                 = y_s1;
	assign push_z                 = z_s1;
	assign push_flags.above_open  = mag_c >= open_c;
	assign push_flags.below_close = mag_c < close_c;
endmodule

// ===== hw/rtl/ngh_fifo.sv =====
module ngh_fifo #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] push_x,
	input  logic signed [SAMPLE_WIDTH-1:0] push_y,
	input  logic signed [SAMPLE_WIDTH-1:0] push_z,
	input  ngh_pkg::cmp_flags_t push_flags,
	output logic pop_valid,
	input  logic pop_ready,
	output logic signed [SAMPLE_WIDTH-1:0] pop_x,
	output logic signed [SAMPLE_WIDTH-1:0] pop_y,
	output logic signed [SAMPLE_WIDTH-1:0] pop_z,
	output ngh_pkg::cmp_flags_t pop_flags
);
	import ngh_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic signed [SAMPLE_WIDTH-1:0] x_q [DEPTH];
	logic signed [SAMPLE_WIDTH-1:0] y_q [DEPTH];
	logic signed [SAMPLE_WIDTH-1:0] z_q [DEPTH];
	cmp_flags_t flags_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			x_q[wr_ptr_q]     <= push_x;
			y_q[wr_ptr_q]     <= push_y;
			z_q[wr_ptr_q]     <= push_z;
			flags_q[wr_ptr_q] <= push_flags;
		end
	end

	assign pop_x     = x_q[rd_ptr_q];
	assign pop_y     = y_q[rd_ptr_q];
	assign pop_z     = z_q[rd_ptr_q];
	assign pop_flags = flags_q[rd_ptr_q];
endmodule

// ===== hw/rtl/ngh_back.sv =====
module ngh_back #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEFF_WIDTH  = 16,
	parameter int HOLD_WIDTH   = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	output logic pop_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] pop_x,
	input  logic signed [SAMPLE_WIDTH-1:0] pop_y,
	input  logic signed [SAMPLE_WIDTH-1:0] pop_z,
	input  ngh_pkg::cmp_flags_t pop_flags,
	input  logic [COEFF_WIDTH-1:0] attack_coeff,
	input  logic [COEFF_WIDTH-1:0] release_coeff,
	input  logic [HOLD_WIDTH-1:0] hold_samples,
	input  logic mute_mode,
	ngh_out_if.source results
);
	import ngh_pkg::*;

	localparam int EPROD_W = ENV_W + COEFF_WIDTH;
	localparam int SPROD_W = SAMPLE_WIDTH + ENV_W + 1;

	bk_state_t state_q, state_n;
	phase_t phase_q, phase_n;
	logic [ENV_W-1:0] env_q, env_pre, env_n, mul_a, step;
	logic [HOLD_WIDTH-1:0] hold_q, hold_n, hold_dec;
	logic [COEFF_WIDTH-1:0] coeff;
	logic [EPROD_W-1:0] eprod;
	logic opening;
	logic do_step, do_load;

	logic signed [SAMPLE_WIDTH-1:0] x_q, y_q, z_q;
	logic signed [SPROD_W-1:0] px, py, pz;
	logic signed [ENV_W:0] env_s;

	logic out_v_q;
	logic signed [SAMPLE_WIDTH-1:0] out_x_q, out_y_q, out_z_q;
	phase_t out_phase_q;
	logic [ENV_W-1:0] out_env_q;

	// sequencer: step the gate, then scale and hand off
	always_comb begin
		state_n   = state_q;
		pop_ready = 1'b0;
		do_step   = 1'b0;
		do_load   = 1'b0;
		case (state_q)
			BK_STEP: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					do_step = 1'b1;
					state_n = BK_SCALE;
				end
			end
			BK_SCALE: begin
				if (!out_v_q || results.ready) begin
					do_load = 1'b1;
					state_n = BK_STEP;
				end
			end
			default: state_n = BK_STEP;
		endcase
	end

	// gate phase and envelope step
	always_comb begin
		phase_n  = phase_q;
		env_pre  = env_q;
		hold_n   = hold_q;
		hold_dec = (hold_q > HOLD_WIDTH'(1)) ? hold_q - 1'b1 : '0;
		case (phase_q)
			PH_CLOSED: begin
				if (pop_flags.above_open) phase_n = PH_ATTACK;
			end
			PH_ATTACK: begin
				if (env_q >= ENV_OPEN_AT) begin
					phase_n = PH_OPEN;
					env_pre = ENV_ONE;
				end
			end
			PH_OPEN: begin
				if (pop_flags.below_close) begin
					phase_n = PH_HOLD;
					hold_n  = hold_samples;
				end
			end
			PH_HOLD: begin
				if (pop_flags.above_open) begin
					phase_n = PH_OPEN;
				end else begin
					hold_n = hold_dec;
					if (hold_dec == '0) phase_n = PH_RELEASE;
				end
			end
			PH_RELEASE: begin
				if (pop_flags.above_open) begin
					phase_n = PH_ATTACK;
				end else if (env_q <= ENV_CLOSE_AT) begin
					phase_n = PH_CLOSED;
					env_pre = '0;
				end
			end
			default: phase_n = PH_CLOSED;
		endcase
		opening = phase_n inside {PH_ATTACK, PH_OPEN, PH_HOLD};
		mul_a   = opening ? ENV_ONE - env_pre : env_pre;
		coeff   = opening ? attack_coeff : release_coeff;
		eprod   = EPROD_W'(mul_a) * EPROD_W'(coeff);
		step    = eprod[EPROD_W-1:COEFF_WIDTH];
		env_n   = opening ? ENV_ONE - step : step;
	end

	// floor(sample * env / 2^16)
	assign env_s = $signed({1'b0, env_q});
	assign px    = x_q * env_s;
	assign py    = y_q * env_s;
	assign pz    = z_q * env_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_STEP;
			phase_q <= PH_CLOSED;
			env_q   <= '0;
			hold_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (do_step) begin
				phase_q <= phase_n;
				env_q   <= env_n;
				hold_q  <= hold_n;
			end
			if (do_load) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			x_q <= pop_x;
			y_q <= pop_y;
			z_q <= pop_z;
		end
		if (do_load) begin
			out_x_q     <= mute_mode ? px[SAMPLE_WIDTH+15:16] : x_q;
			out_y_q     <= mute_mode ? py[SAMPLE_WIDTH+15:16] : y_q;
			out_z_q     <= pz[SAMPLE_WIDTH+15:16];
			out_phase_q <= phase_q;
			out_env_q   <= env_q;
		end
	end

	assign results.valid          = out_v_q;
	assign results.out_x          = out_x_q;
	assign results.out_y          = out_y_q;
	assign results.out_z          = out_z_q;
	assign results.gate_phase     = out_phase_q;
	assign results.envelope_level = out_env_q;
endmodule

// ===== hw/rtl/xy_noise_gate_with_hold.sv =====
// Channel   Dir  Word                                   Handshake
// samples   in   in_x, in_y, in_z                       valid / ready
// results   out  out_x, out_y, out_z, gate_phase,       valid / ready
//                envelope_level
// cfg       in   cfg_index, cfg_data                    cfg_we, no back-pressure
//
// The back end's envelope loop (gate step with its coefficient multiply, then
// the output scale multiply) takes a new word only after loading the last one.
// Words pass the front end register, queue, gate step and output register.
// Reset is asynchronous, active low; it closes the gate, zeroes the envelope
// and hold count, and clears valid flags, queue pointers and config registers;
// data registers are not reset. No clearing pass. A two-word queue between the
// squaring front end and the gate lets either side stall without holding the other.
module xy_noise_gate_with_hold #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEFF_WIDTH  = 16,
	parameter int HOLD_WIDTH   = 20
) (
	input  logic clk,
	input  logic arst_n,
	ngh_in_if.sink samples,
	ngh_out_if.source results,
	input  logic cfg_we,
	input  logic [ngh_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ngh_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ngh_pkg::*;

	// configuration registers
	logic [LEVEL_W-1:0] open_level_q, close_level_q;
	logic [COEFF_WIDTH-1:0] attack_coeff_q, release_coeff_q;
	logic [HOLD_WIDTH-1:0] hold_samples_q;
	logic mute_mode_q;

	// front end to queue
	logic f_valid, f_ready;
	logic signed [SAMPLE_WIDTH-1:0] f_x, f_y, f_z;
	cmp_flags_t f_flags;

	// queue to gate
	logic q_valid, q_ready;
	logic signed [SAMPLE_WIDTH-1:0] q_x, q_y, q_z;
	cmp_flags_t q_flags;

	// unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_level_q    <= '0;
			close_level_q   <= '0;
			attack_coeff_q  <= '0;
			release_coeff_q <= '0;
			hold_samples_q  <= '0;
			mute_mode_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OPEN_LEVEL:    open_level_q    <= cfg_data[LEVEL_W-1:0];
				REG_CLOSE_LEVEL:   close_level_q   <= cfg_data[LEVEL_W-1:0];
				REG_ATTACK_COEFF:  attack_coeff_q  <= cfg_data[COEFF_WIDTH-1:0];
				REG_RELEASE_COEFF: release_coeff_q <= cfg_data[COEFF_WIDTH-1:0];
				REG_HOLD_SAMPLES:  hold_samples_q  <= cfg_data[HOLD_WIDTH-1:0];
				REG_MUTE_MODE:     mute_mode_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// squares and level compares
	ngh_front #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.samples       (samples),
		.open_level_sq (open_level_q),
		.close_level_sq(close_level_q),
		.push_valid    (f_valid),
		.push_ready    (f_ready),
		.push_x        (f_x),
		.push_y        (f_y),
		.push_z        (f_z),
		.push_flags    (f_flags)
	);

	ngh_fifo #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_x    (f_x),
		.push_y    (f_y),
		.push_z    (f_z),
		.push_flags(f_flags),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_x     (q_x),
		.pop_y     (q_y),
		.pop_z     (q_z),
		.pop_flags (q_flags)
	);

	// gate state, envelope and output scaling
	ngh_back #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COEFF_WIDTH (COEFF_WIDTH),
		.HOLD_WIDTH  (HOLD_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (q_valid),
		.pop_ready    (q_ready),
		.pop_x        (q_x),
		.pop_y        (q_y),
		.pop_z        (q_z),
		.pop_flags    (q_flags),
		.attack_coeff (attack_coeff_q),
		.release_coeff(release_coeff_q),
		.hold_samples (hold_samples_q),
		.mute_mode    (mute_mode_q),
		.results      (results)
	);
endmodule

// ===== test/tb_xy_noise_gate_with_hold.sv =====
`timescale 1ns / 100ps

module tb_xy_noise_gate_with_hold;
	import ngh_pkg::*;

	localparam int SAMPLE_W        = 16;
	localparam int COEFF_W         = 16;
	localparam int HOLD_W          = 20;
	localparam int N_PHASES        = 8;    // random config phases, last one runs without idling
	localparam int WORDS_PER_PHASE = 92;
	localparam int STALL_AT        = 250;  // results seen before the long sink hold-off
	localparam int LONG_STALL      = 150;  // cycles of that hold-off
	localparam int DRAIN_CYCLES    = 20;   // settle time after the last result, > latency

	// indexes with no register behind them, writes must be dropped
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 32'h8000_0000;  // 2 * 32768^2
	localparam logic [COEFF_W-1:0] COEFF_MAX = '1;
	localparam logic [HOLD_W-1:0]  HOLD_MAX  = '1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// one result word
	typedef struct {
		sample_t x;
		sample_t y;
		sample_t z;
		phase_t ph;
		logic [ENV_W-1:0] env;
	} gate_word_t;

	typedef enum logic {
		ROW_REG  = 1'b0,
		ROW_WORD = 1'b1
	} row_kind_t;

	// directed table row: a register write or a sample word, optionally with a
	// hand-written result
	typedef struct {
		row_kind_t kind;
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		sample_t x;
		sample_t y;
		sample_t z;
		bit typed;
		gate_word_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ngh_in_if #(.SAMPLE_WIDTH(SAMPLE_W)) samples_ch ();
	ngh_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) results_ch ();

	xy_noise_gate_with_hold #(
		.SAMPLE_WIDTH(SAMPLE_W),
		.COEFF_WIDTH(COEFF_W),
		.HOLD_WIDTH(HOLD_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_ch),
		.results(results_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// gate model: register copy
	logic [LEVEL_W-1:0] open_sq  = '0;
	logic [LEVEL_W-1:0] close_sq = '0;
	logic [COEFF_W-1:0] atk_k    = '0;
	logic [COEFF_W-1:0] rel_k    = '0;
	logic [HOLD_W-1:0]  hold_len = '0;
	logic               mute     = 1'b0;

	// gate model: state
	phase_t             gate_ph   = PH_CLOSED;
	logic [ENV_W-1:0]   gate_env  = '0;
	logic [HOLD_W-1:0]  hold_left = '0;

	gate_word_t expected_words[$];  // one per accepted sample word, oldest first
	stim_row_t  stim_rows[$];
	int         idle_pct     = 0;   // idle burst odds, shared by both sides
	int         results_seen = 0;
	bit         failed       = 1'b0;

	// floor(s * env / 2^16)
	function automatic sample_t scale_env(sample_t s, logic [ENV_W-1:0] e);
		longint p;
		p = longint'(s) * longint'(e);
		return sample_t'(p >>> 16);
	endfunction

	// advance the gate by one sample word and return the word it should emit
	function automatic gate_word_t gate_step(sample_t sx, sample_t sy, sample_t sz);
		longint unsigned mag;
		longint unsigned env_gap;
		longint unsigned prod;
		logic above_open;
		logic below_close;
		gate_word_t res;
		// full width, never saturates: max is exactly 2^31
		mag = longint'(sx) * sx + longint'(sy) * sy;
		above_open = mag >= open_sq;
		below_close = mag < close_sq;

		// phase moves on the envelope as it stands
		case (gate_ph)
			PH_CLOSED: begin
				if (above_open)
					gate_ph = PH_ATTACK;
			end
			PH_ATTACK: begin
				if (gate_env >= ENV_OPEN_AT) begin
					gate_ph = PH_OPEN;
					gate_env = ENV_ONE;
				end
			end
			PH_OPEN: begin
				if (below_close) begin
					gate_ph = PH_HOLD;
					hold_left = hold_len;
				end
			end
			PH_HOLD: begin
				if (above_open) begin
					gate_ph = PH_OPEN;
				end else begin
					// zero hold behaves as one
					hold_left = (hold_left > 1) ? hold_left - 1'b1 : '0;
					if (hold_left == 0)
						gate_ph = PH_RELEASE;
				end
			end
			PH_RELEASE: begin
				if (above_open) begin
					gate_ph = PH_ATTACK;
				end else if (gate_env <= ENV_CLOSE_AT) begin
					gate_ph = PH_CLOSED;
					gate_env = '0;
				end
			end
			default: gate_ph = PH_CLOSED;
		endcase

		// one-pole step toward unity or zero
		if (gate_env > ENV_ONE)
			gate_env = ENV_ONE;
		if (gate_ph == PH_ATTACK || gate_ph == PH_OPEN || gate_ph == PH_HOLD) begin
			env_gap = ENV_ONE - gate_env;
			prod = env_gap * atk_k;
			gate_env = ENV_ONE - ENV_W'(prod >> COEFF_W);
		end else begin
			prod = longint'(gate_env) * rel_k;
			gate_env = ENV_W'(prod >> COEFF_W);
		end

		res.x = mute ? scale_env(sx, gate_env) : sx;
		res.y = mute ? scale_env(sy, gate_env) : sy;
		res.z = scale_env(sz, gate_env);
		res.ph = gate_ph;
		res.env = gate_env;
		return res;
	endfunction

	function automatic void add_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		stim_row_t r;
		r.kind = ROW_REG;
		r.idx = idx;
		r.data = data;
		r.typed = 1'b0;
		stim_rows.push_back(r);
	endfunction

	function automatic void add_word(sample_t x, sample_t y, sample_t z);
		stim_row_t r;
		r.kind = ROW_WORD;
		r.x = x;
		r.y = y;
		r.z = z;
		r.typed = 1'b0;
		stim_rows.push_back(r);
	endfunction

	function automatic void add_checked(sample_t x, sample_t y, sample_t z, sample_t ox,
			sample_t oy, sample_t oz, phase_t ph, logic [ENV_W-1:0] env);
		stim_row_t r;
		r.kind = ROW_WORD;
		r.x = x;
		r.y = y;
		r.z = z;
		r.typed = 1'b1;
		r.want.x = ox;
		r.want.y = oy;
		r.want.z = oz;
		r.want.ph = ph;
		r.want.env = env;
		stim_rows.push_back(r);
	endfunction

	// Leaves cfg_we high so back-to-back writes need no toggle; the caller
	// lowers it. The block is idle here, so the model copy updates right away.
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_OPEN_LEVEL:    open_sq = data;
			REG_CLOSE_LEVEL:   close_sq = data;
			REG_ATTACK_COEFF:  atk_k = data[COEFF_W-1:0];
			REG_RELEASE_COEFF: rel_k = data[COEFF_W-1:0];
			REG_HOLD_SAMPLES:  hold_len = data[HOLD_W-1:0];
			REG_MUTE_MODE:     mute = data[0];
			default: ;
		endcase
	endtask

	// Stop offering and wait until every expected word is back. One result per
	// sample word, so an empty queue means the block is idle.
	task automatic drain();
		samples_ch.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	// Offer one sample word, optionally after an idle burst. Valid stays high on
	// return so the next word can follow with no bubble.
	task automatic send_word(sample_t x, sample_t y, sample_t z, bit typed, gate_word_t want);
		gate_word_t predicted;
		if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
			samples_ch.valid <= 1'b0;
			repeat ($urandom_range(16, 1))
				@(posedge clk);
		end
		samples_ch.valid <= 1'b1;
		samples_ch.in_x <= x;
		samples_ch.in_y <= y;
		samples_ch.in_z <= z;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
		// model always steps; a typed row overrides what gets compared
		predicted = gate_step(x, y, z);
		if (typed)
			expected_words.push_back(want);
		else
			expected_words.push_back(predicted);
	endtask

	// result checker, samples at the edge so it sees pre-edge values
	always @(posedge clk) begin
		gate_word_t want;
		if (results_ch.valid && results_ch.ready) begin
			results_seen++;
			if (expected_words.size() == 0) begin
				$error("unexpected result word: x=%0d y=%0d z=%0d phase=%0d env=%0d",
					results_ch.out_x, results_ch.out_y, results_ch.out_z,
					results_ch.gate_phase, results_ch.envelope_level);
				failed = 1'b1;
			end else begin
				want = expected_words.pop_front();
				if (results_ch.out_x !== want.x) begin
					$error("out_x: expected %0d, got %0d", want.x, results_ch.out_x);
					failed = 1'b1;
				end
				if (results_ch.out_y !== want.y) begin
					$error("out_y: expected %0d, got %0d", want.y, results_ch.out_y);
					failed = 1'b1;
				end
				if (results_ch.out_z !== want.z) begin
					$error("out_z: expected %0d, got %0d", want.z, results_ch.out_z);
					failed = 1'b1;
				end
				if (results_ch.gate_phase !== want.ph) begin
					$error("gate_phase: expected %0d, got %0d", want.ph, results_ch.gate_phase);
					failed = 1'b1;
				end
				if (results_ch.envelope_level !== want.env) begin
					$error("envelope_level: expected %0d, got %0d", want.env,
						results_ch.envelope_level);
					failed = 1'b1;
				end
			end
		end
	end

	// result sink: random stall bursts, plus one long hold-off so the internal
	// queue fills and the sample side backs up
	initial begin
		bit stalled_long;
		stalled_long = 1'b0;
		results_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!stalled_long && results_seen >= STALL_AT) begin
				stalled_long = 1'b1;
				results_ch.ready <= 1'b0;
				repeat (LONG_STALL)
					@(posedge clk);
			end else if (idle_pct != 0 && $urandom_range(399, 0) < idle_pct) begin
				results_ch.ready <= 1'b0;
				repeat ($urandom_range(16, 1))
					@(posedge clk);
			end
			results_ch.ready <= 1'b1;
		end
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("[xy_noise_gate_with_hold] ERROR");
		$finish;
	end

	initial begin
		row_kind_t prev_kind;
		gate_word_t no_want;
		int r;
		int lim;
		int a;
		int sent;
		int seg_kind;
		int seg_len;
		sample_t x;
		sample_t y;
		sample_t z;
		sample_t t;
		logic [LEVEL_W-1:0] close_v;
		logic [COEFF_W-1:0] coeff_v;
		logic [HOLD_W-1:0] hold_v;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		samples_ch.valid <= 1'b0;
		samples_ch.in_x <= '0;
		samples_ch.in_y <= '0;
		samples_ch.in_z <= '0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;

		// Reset registers: every level is zero so any word counts as loud, and
		// zero attack jumps straight to unity. Gate opens on word two and stays.
		add_checked(100, -200, 5000, 100, -200, 5000, PH_ATTACK, ENV_ONE);
		add_checked(-32768, -32768, -32768, -32768, -32768, -32768, PH_OPEN, ENV_ONE);
		add_checked(32767, 32767, 32767, 32767, 32767, 32767, PH_OPEN, ENV_ONE);
		add_checked(0, 0, 0, 0, 0, 0, PH_OPEN, ENV_ONE);
		add_checked(-1, 1, -1, -1, 1, -1, PH_OPEN, ENV_ONE);

		// top levels, slowest coefficients, zero hold, mute on; spare indexes
		// must not disturb anything
		add_reg(REG_OPEN_LEVEL, LEVEL_MAX);
		add_reg(REG_CLOSE_LEVEL, LEVEL_MAX);
		add_reg(REG_ATTACK_COEFF, CFG_DATA_W'(COEFF_MAX));
		add_reg(REG_RELEASE_COEFF, CFG_DATA_W'(COEFF_MAX));
		add_reg(REG_HOLD_SAMPLES, '0);
		add_reg(REG_MUTE_MODE, 32'd1);
		add_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
		add_reg(REG_SPARE_HI, 32'h1234_5678);
		add_word(0, 0, 1234);           // open -> hold
		add_word(3, -4, -1234);         // zero hold: release one word later
		add_word(-32768, -32768, 32767); // magnitude 2^31 just reaches open level
		add_word(-32768, -32768, -32768);
		add_word(32767, -32768, 1000);  // 65535 under 2^31, below close -> hold

		// mid levels, half attack, instant release, short hold, mute off
		add_reg(REG_OPEN_LEVEL, 32'd400_000_000);
		add_reg(REG_CLOSE_LEVEL, 32'd100_000_000);
		add_reg(REG_ATTACK_COEFF, 32'd32768);
		add_reg(REG_RELEASE_COEFF, '0);
		add_reg(REG_HOLD_SAMPLES, 32'd3);
		add_reg(REG_MUTE_MODE, '0);
		add_word(1000, -1000, 777);
		add_word(0, 0, -777);
		add_word(20000, 0, 30000);      // exactly on the open level
		add_word(-20000, 5, -30000);
		add_word(32767, 32767, 12345);
		add_word(19999, 0, -12345);

		// instant attack, longest hold, mute on
		add_reg(REG_ATTACK_COEFF, '0);
		add_reg(REG_HOLD_SAMPLES, CFG_DATA_W'(HOLD_MAX));
		add_reg(REG_MUTE_MODE, 32'd1);
		add_word(25000, 0, 4000);
		add_word(0, 25000, -4000);
		add_word(100, 100, 32767);      // enter hold with max count
		add_word(-100, 100, -32768);
		add_word(30000, 0, 1);          // loud again: back to open
		add_word(-1, -1, -32768);

		idle_pct = 20;
		prev_kind = ROW_WORD;
		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_REG) begin
				if (prev_kind != ROW_REG)
					drain();
				write_reg(stim_rows[i].idx, stim_rows[i].data);
			end else begin
				if (prev_kind == ROW_REG)
					cfg_we <= 1'b0;
				send_word(stim_rows[i].x, stim_rows[i].y, stim_rows[i].z,
					stim_rows[i].typed, stim_rows[i].want);
			end
			prev_kind = stim_rows[i].kind;
		end

		// Random phases. Open level is r^2 and close (r/2)^2, so loud words
		// (one axis at or past r) and quiet words (both axes within r/4) drive
		// the gate round its whole cycle. Some phases get an arbitrary close
		// level, which may sit above open.
		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			r = $urandom_range(32767, 0);
			case ($urandom_range(7, 0))
				0: r = 0;
				1: r = 32767;
				default: ;
			endcase
			if ($urandom_range(3, 0) == 0)
				close_v = $urandom_range(LEVEL_MAX, 0);
			else
				close_v = (r / 2) * (r / 2);
			write_reg(REG_OPEN_LEVEL, r * r);
			write_reg(REG_CLOSE_LEVEL, close_v);

			case ($urandom_range(3, 0))
				0: coeff_v = '0;
				1: coeff_v = COEFF_MAX;
				default: coeff_v = COEFF_W'($urandom_range(COEFF_MAX, 1));
			endcase
			write_reg(REG_ATTACK_COEFF, CFG_DATA_W'(coeff_v));

			// release mostly fast enough to close inside a quiet stretch
			case ($urandom_range(7, 0))
				0: coeff_v = '0;
				1: coeff_v = COEFF_MAX;
				default: coeff_v = COEFF_W'($urandom_range(62000, 20000));
			endcase
			write_reg(REG_RELEASE_COEFF, CFG_DATA_W'(coeff_v));

			case ($urandom_range(7, 0))
				0: hold_v = HOLD_MAX;
				1: hold_v = HOLD_W'($urandom_range(HOLD_MAX, 0));
				2: hold_v = '0;
				default: hold_v = HOLD_W'($urandom_range(40, 1));
			endcase
			write_reg(REG_HOLD_SAMPLES, CFG_DATA_W'(hold_v));
			write_reg(REG_MUTE_MODE, $urandom_range(1, 0));
			if ($urandom_range(3, 0) == 0)
				write_reg(REG_SPARE_HI, $urandom());
			cfg_we <= 1'b0;

			if (p == N_PHASES - 1) begin
				idle_pct = 0;
			end else begin
				case ($urandom_range(3, 0))
					0: idle_pct = 0;
					1: idle_pct = 10;
					2: idle_pct = 30;
					default: idle_pct = 60;
				endcase
			end

			lim = r / 4;
			sent = 0;
			while (sent < WORDS_PER_PHASE) begin
				seg_kind = $urandom_range(99, 0);
				if (seg_kind < 35)
					seg_len = $urandom_range(40, 1);   // loud stretch
				else if (seg_kind < 80)
					seg_len = $urandom_range(120, 1);  // quiet stretch
				else
					seg_len = $urandom_range(12, 1);   // noise
				for (int k = 0; k < seg_len && sent < WORDS_PER_PHASE; k++) begin
					z = sample_t'($urandom());
					if (seg_kind < 35) begin
						// |x| in [r, 32768]; +32768 wraps to -32768, still loud
						a = $urandom_range(32768, r);
						x = sample_t'($urandom_range(1, 0) ? -a : a);
						y = sample_t'($urandom());
						if ($urandom_range(1, 0)) begin
							t = x;
							x = y;
							y = t;
						end
					end else if (seg_kind < 80) begin
						x = sample_t'(int'($urandom_range(2 * lim, 0)) - lim);
						y = sample_t'(int'($urandom_range(2 * lim, 0)) - lim);
					end else begin
						x = sample_t'($urandom());
						y = sample_t'($urandom());
					end
					send_word(x, y, z, 1'b0, no_want);
					sent++;
				end
			end
		end

		drain();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (!failed && expected_words.size() == 0)
			$display("[xy_noise_gate_with_hold] OK");
		else
			$display("[xy_noise_gate_with_hold] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/ngh_pkg.sv
hw/rtl/ngh_in_if.sv
hw/rtl/ngh_out_if.sv
hw/rtl/ngh_front.sv
hw/rtl/ngh_fifo.sv
hw/rtl/ngh_back.sv
hw/rtl/xy_noise_gate_with_hold.sv
test/tb_xy_noise_gate_with_hold.sv
